/* rtl/mgp_pkg.sv */
`default_nettype none
package mgp_pkg;

   localparam logic [2:0] OP_WRITE   = 3'd0;
   localparam logic [2:0] OP_READ    = 3'd1;
   localparam logic [2:0] OP_PREDICT = 3'd2;
   localparam logic [2:0] OP_AVERAGE = 3'd3;
   localparam logic [2:0] OP_COPY    = 3'd4;

   localparam logic [2:0] CSR_DIMENSION    = 3'd0;
   localparam logic [2:0] CSR_FINEST_LEVEL = 3'd1;
   localparam logic [2:0] CSR_NEUMANN_X    = 3'd2;
   localparam logic [2:0] CSR_NEUMANN_Y    = 3'd3;
   localparam logic [2:0] CSR_NEUMANN_Z    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TERMS,
      ST_DRAIN,
      ST_WRBACK,
      ST_COPY,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_READ,
      SEL_CALC
   } sel_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  level;
      logic [4:0]  xi;
      logic [4:0]  yi;
      logic [4:0]  zi;
      logic [2:0]  quantity;
      logic [31:0] write_value;
   } item_type;

   typedef struct packed {
      logic [1:0] dim;      // effective, 1..3
      logic [2:0] level;    // effective finest level
      logic [2:0] mirror;   // z, y, x
   } cfg_type;

   typedef struct packed {
      logic    load;
      logic    write_cell;
      logic    term_step;
      logic    write_calc;
      logic    copy_step;
      logic    emit;
      sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       bad;
      logic       term_last;
      logic       copy_last;
      logic       pipe_busy;
   } status_type;

endpackage
`default_nettype wire

/* rtl/mgp_ctrl.sv */
`default_nettype none
module mgp_ctrl
   import mgp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_fire,
   input  wire logic       rsp_busy,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            idle
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.sel  = SEL_ZERO;
      idle     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_WRITE: begin
                  cmd.write_cell = 1'b1;
                  state_in       = ST_FINISH;
               end
               OP_PREDICT, OP_AVERAGE: begin
                  state_in = status.bad ? ST_FINISH : ST_TERMS;
               end
               OP_COPY: state_in = ST_COPY;
               default: state_in = ST_FINISH;
            endcase
         end
         ST_TERMS: begin
            cmd.term_step = 1'b1;
            if (status.term_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = (status.op == OP_COPY) ? ST_FINISH : ST_WRBACK;
            end
         end
         ST_WRBACK: begin
            cmd.write_calc = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.op == OP_READ) begin
               cmd.sel = SEL_READ;
            end else if ((status.op == OP_PREDICT || status.op == OP_AVERAGE)
                         && !status.bad) begin
               cmd.sel = SEL_CALC;
            end
            if (!rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/mgp_datapath.sv */
`default_nettype none
module mgp_datapath
   import mgp_pkg::*;
#(
   parameter int MAX_LEVEL  = 4,
   parameter int QUANTITIES = 8,
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire item_type    item,
   input  wire cmd_type     cmd,
   output status_type       status,
   output logic [31:0]      value,
   output logic             bad_level
);

   localparam int CW    = MAX_LEVEL + 1;
   localparam int EDGE  = (1 << MAX_LEVEL) + 1;
   localparam int CELLS = EDGE * EDGE * EDGE * QUANTITIES;
   localparam int AW    = $clog2(CELLS);
   localparam int QW    = (QUANTITIES > 1) ? $clog2(QUANTITIES) : 1;
   localparam int RW    = (CW > 5) ? CW : 5;
   localparam int IW    = ((CW > 4) ? CW : 4) + 2;
   localparam int ACC_W = VALUE_BITS + 16;

   localparam logic signed [ACC_W-1:0] VMAX =
      {{(ACC_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] VMIN =
      {{(ACC_W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] OMAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] OMIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] z,
                                             input logic [QW-1:0] q);
      logic [AW-1:0] t;
      t = AW'(z) * AW'(EDGE) + AW'(y);
      t = t * AW'(EDGE) + AW'(x);
      return t * AW'(QUANTITIES) + AW'(q);
   endfunction

   function automatic logic [VALUE_BITS-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      if (v > VMAX) return VMAX[VALUE_BITS-1:0];
      if (v < VMIN) return VMIN[VALUE_BITS-1:0];
      return v[VALUE_BITS-1:0];
   endfunction

   function automatic logic [31:0] sat_out(input logic [VALUE_BITS-1:0] w);
      logic signed [ACC_W-1:0] v;
      v = {{(ACC_W-VALUE_BITS){w[VALUE_BITS-1]}}, w};
      if (v > OMAX) return OMAX[31:0];
      if (v < OMIN) return OMIN[31:0];
      return v[31:0];
   endfunction

   logic [VALUE_BITS-1:0] result_mem [CELLS];
   logic [VALUE_BITS-1:0] source_mem [CELLS];

   // item registers
   logic [2:0]            op_ff, lvl_ff;
   logic [4:0]            raw_ff [3];
   logic [CW-1:0]         cell_ff [3];
   logic [QW-1:0]         q_ff;
   logic [VALUE_BITS-1:0] wsat_ff;
   logic [2:0]            used_ff;
   logic                  bad_ff;

   // term sequencing and pipeline
   logic signed [1:0]       off_ff [3];
   logic                    s1_valid_ff, s2_valid_ff;
   logic [CW-1:0]           s1_c_ff [3];
   logic [3:0]              s1_shift_ff, s2_shift_ff;
   logic                    s1_neg_ff, s2_neg_ff;
   logic [VALUE_BITS-1:0]   src_rd_ff, res_rd_ff, calc_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic [AW-1:0] copy_addr_ff, copy_waddr_ff;
   logic          copy_valid_ff;

   logic              pred;
   logic [2:0]        top_exp, nexp;
   logic [CW-1:0]     top;
   logic [IW-1:0]     n_val, m2_mask, n_mask;
   logic [CW-1:0]     coord [3];
   logic [1:0]        hi_off [3];
   logic [1:0]        zeros;
   logic [3:0]        shift;
   logic              neg;
   logic              last;
   logic [AW-1:0]     cell_addr, src_addr, res_raddr;
   logic [2:0]        used_in;
   logic [4:0]        raw_in [3];
   logic [2:0]        q_sel;
   logic signed [ACC_W-1:0] wv_ext, term, acc_floor;
   logic [VALUE_BITS-1:0]   calc_vb;

   assign top_exp = cfg.level;
   assign top     = CW'(1) << top_exp;
   assign used_in = {cfg.dim == 2'd3, cfg.dim != 2'd1, 1'b1};
   assign raw_in[0] = used_in[0] ? item.xi : 5'd0;
   assign raw_in[1] = used_in[1] ? item.yi : 5'd0;
   assign raw_in[2] = used_in[2] ? item.zi : 5'd0;
   assign q_sel   = ({2'b00, item.quantity} >= 5'(QUANTITIES)) ?
                    3'(QUANTITIES - 1) : item.quantity;
   assign wv_ext  = {{(ACC_W-32){item.write_value[31]}}, item.write_value};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= item.op;
         lvl_ff  <= item.level;
         q_ff    <= QW'(q_sel);
         wsat_ff <= sat_word(wv_ext);
         used_ff <= used_in;
         bad_ff  <= (item.op == OP_PREDICT) &&
                    (item.level == 3'd0 || item.level > cfg.level);
         for (int a = 0; a < 3; a++) begin
            raw_ff[a]  <= raw_in[a];
            cell_ff[a] <= (RW'(raw_in[a]) > RW'(top)) ? top : CW'(raw_in[a]);
         end
      end
   end

   // stencil offsets and coordinates of the current term
   assign pred    = (op_ff == OP_PREDICT);
   assign nexp    = pred ? (lvl_ff - 3'd1) : top_exp;
   assign n_val   = IW'(1) << nexp;
   assign n_mask  = n_val - IW'(1);
   assign m2_mask = (n_val << 1) - IW'(1);

   always_comb begin
      zeros = 2'd0;
      neg   = 1'b0;
      last  = 1'b1;
      for (int a = 0; a < 3; a++) begin
         logic [IW-1:0] base, idx, m2, m;
         base = pred ? IW'(raw_ff[a] >> 1) : IW'(cell_ff[a]);
         idx  = base + {{(IW-2){off_ff[a][1]}}, off_ff[a]};
         m2   = idx & m2_mask;
         if (cfg.mirror[a]) begin
            m  = ((m2 & n_val) != '0) ? (~m2 & n_mask) : m2;
         end else begin
            m  = idx & n_mask;
         end
         coord[a]  = used_ff[a] ? m[CW-1:0] : '0;
         hi_off[a] = (used_ff[a] && pred) ? 2'sd1 : 2'sd0;
         if (off_ff[a] == 2'sd0) begin
            zeros = zeros + 2'd1;
         end
         if ((off_ff[a] == 2'sd1 && !raw_ff[a][0]) ||
             (off_ff[a] == -2'sd1 && raw_ff[a][0])) begin
            neg = ~neg;
         end
         if (off_ff[a] != hi_off[a]) begin
            last = 1'b0;
         end
      end
      zeros = zeros + ((~used_ff[1]) ? 2'd0 : 2'd0);
      shift = pred ? 4'(zeros) * 4'd3 : 4'd9 - 4'(cfg.dim);
      if (!pred) begin
         neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         off_ff[0] <= -2'sd1;
         off_ff[1] <= used_in[1] ? -2'sd1 : 2'sd0;
         off_ff[2] <= used_in[2] ? -2'sd1 : 2'sd0;
      end else if (cmd.term_step) begin
         if (off_ff[0] != hi_off[0]) begin
            off_ff[0] <= off_ff[0] + 2'sd1;
         end else begin
            off_ff[0] <= -2'sd1;
            if (off_ff[1] != hi_off[1]) begin
               off_ff[1] <= off_ff[1] + 2'sd1;
            end else begin
               off_ff[1] <= used_ff[1] ? -2'sd1 : 2'sd0;
               off_ff[2] <= off_ff[2] + 2'sd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         copy_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= cmd.term_step;
         s2_valid_ff   <= s1_valid_ff;
         copy_valid_ff <= cmd.copy_step;
      end
   end

   always_ff @(posedge clock) begin
      s1_c_ff     <= coord;
      s1_shift_ff <= shift;
      s1_neg_ff   <= neg;
      s2_shift_ff <= s1_shift_ff;
      s2_neg_ff   <= s1_neg_ff;
      copy_waddr_ff <= copy_addr_ff;
      if (cmd.load) begin
         copy_addr_ff <= '0;
      end else if (cmd.copy_step) begin
         copy_addr_ff <= copy_addr_ff + AW'(1);
      end
   end

   // memories
   assign cell_addr = addr_of(cell_ff[0], cell_ff[1], cell_ff[2], q_ff);
   assign src_addr  = addr_of(s1_c_ff[0], s1_c_ff[1], s1_c_ff[2], q_ff);
   assign res_raddr = cmd.copy_step ? copy_addr_ff : cell_addr;

   always_ff @(posedge clock) begin
      if (cmd.write_cell) begin
         result_mem[cell_addr] <= wsat_ff;
      end else if (cmd.write_calc) begin
         result_mem[cell_addr] <= calc_vb;
      end
      res_rd_ff <= result_mem[res_raddr];
   end

   always_ff @(posedge clock) begin
      if (copy_valid_ff) begin
         source_mem[copy_waddr_ff] <= res_rd_ff;
      end
      src_rd_ff <= source_mem[src_addr];
   end

   // accumulation in units of 1/512
   assign term = $signed({{(ACC_W-VALUE_BITS){src_rd_ff[VALUE_BITS-1]}}, src_rd_ff})
                 <<< s2_shift_ff;
   assign acc_floor = acc_ff >>> 9;
   assign calc_vb   = sat_word(acc_floor);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= s2_neg_ff ? acc_ff - term : acc_ff + term;
      end
      if (cmd.write_calc) begin
         calc_ff <= calc_vb;
      end
   end

   always_comb begin
      case (cmd.sel)
         SEL_READ: value = sat_out(res_rd_ff);
         SEL_CALC: value = sat_out(calc_ff);
         default:  value = 32'd0;
      endcase
   end

   assign bad_level        = bad_ff;
   assign status.op        = op_ff;
   assign status.bad       = bad_ff;
   assign status.term_last = last;
   assign status.copy_last = (copy_addr_ff == AW'(CELLS - 1));
   assign status.pipe_busy = s1_valid_ff | s2_valid_ff | copy_valid_ff;

endmodule
`default_nettype wire

/* rtl/multiresolution_grid_predictor_core.sv */
`default_nettype none
// Multiresolution grid predictor. Holds a result grid and a source grid of
// Q16.16 cell words and runs one item at a time. A predict and a point average
// read their stencil through the single read port of the source grid, which
// fetches one stencil cell per cycle. A copy sweeps every word of the result
// grid into the source grid, one word per cycle. The next item is taken as soon
// as the current one is finished, even while its result still waits in the
// output register. Grid contents are undefined until written.
module multiresolution_grid_predictor_core
   import mgp_pkg::*;
#(
   parameter int MAX_LEVEL  = 4,
   parameter int QUANTITIES = 8,
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // level, xi, yi, zi, quantity, write_value
   input  wire logic [2:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // value
   output logic             rsp_tuser,   // bad_level
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [2:0]  csr_wdata
);

   logic [1:0] dim_ff;
   logic [2:0] level_ff;
   logic [2:0] mirror_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_bad_ff;

   cfg_type    cfg;
   item_type   item;
   cmd_type    cmd;
   status_type status;
   logic       idle, req_fire, rsp_busy, bad_level;
   logic [31:0] value;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= 2'd3;
         level_ff  <= 3'd4;
         mirror_ff <= 3'b000;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DIMENSION:    dim_ff       <= csr_wdata[1:0];
            CSR_FINEST_LEVEL: level_ff     <= csr_wdata;
            CSR_NEUMANN_X:    mirror_ff[0] <= csr_wdata[0];
            CSR_NEUMANN_Y:    mirror_ff[1] <= csr_wdata[0];
            CSR_NEUMANN_Z:    mirror_ff[2] <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.dim    = (dim_ff == 2'd0) ? 2'd1 : dim_ff;
   assign cfg.level  = (level_ff == 3'd0) ? 3'd1 :
                       (level_ff > 3'(MAX_LEVEL)) ? 3'(MAX_LEVEL) : level_ff;
   assign cfg.mirror = mirror_ff;

   assign item.op          = req_tuser;
   assign item.level       = req_tdata[2:0];
   assign item.xi          = req_tdata[7:3];
   assign item.yi          = req_tdata[12:8];
   assign item.zi          = req_tdata[17:13];
   assign item.quantity    = req_tdata[20:18];
   assign item.write_value = req_tdata[52:21];

   assign req_tready = idle;
   assign req_fire   = req_tvalid && idle;
   assign rsp_busy   = rsp_valid_ff && !rsp_tready;

   mgp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .rsp_busy (rsp_busy),
      .status   (status),
      .cmd      (cmd),
      .idle     (idle)
   );

   mgp_datapath #(
      .MAX_LEVEL  (MAX_LEVEL),
      .QUANTITIES (QUANTITIES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item      (item),
      .cmd       (cmd),
      .status    (status),
      .value     (value),
      .bad_level (bad_level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= value;
         rsp_bad_ff  <= bad_level;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous item still in flight");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_busy)
      else $error("result overwrote an item not yet taken");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("bad level result carries a nonzero value");

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(cmd.term_step && cmd.copy_step))
      else $error("stencil read and grid copy overlap");

endmodule
`default_nettype wire
